FILE: rtl/core/spng_pkg.sv
// Shared types, constants and CRC-32 helpers for the stored PNG stream encoder.
package spng_pkg;

    // Sequencer phase: which section of the PNG stream is being emitted
    typedef enum logic [3:0] {
        S_HDR  = 4'b0001,
        S_ROW  = 4'b0010,
        S_PIX  = 4'b0100,
        S_TAIL = 4'b1000
    } t_phase;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;

    // Last byte index of each multi-byte section
    localparam logic [5:0] HDR_LAST  = 6'd42;
    localparam logic [5:0] ROW_LAST  = 6'd5;
    localparam logic [5:0] TAIL_LAST = 6'd19;

    // Byte positions where a chunk CRC restarts (first byte of a chunk type)
    localparam logic [5:0] HDR_IHDR_TYPE  = 6'd12;
    localparam logic [5:0] HDR_IDAT_TYPE  = 6'd37;
    localparam logic [5:0] TAIL_IEND_TYPE = 6'd12;

    localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // PNG color types
    localparam logic [7:0] COLOR_RGB  = 8'd2;
    localparam logic [7:0] COLOR_RGBA = 8'd6;

    // Reflected CRC-32 (0xedb88320) table, one nibble at a time
    function automatic logic [31:0] crc_nib(input logic [3:0] nib);
        logic [31:0] v;
        case (nib)
            4'h0: v = 32'h00000000;
            4'h1: v = 32'h1db71064;
            4'h2: v = 32'h3b6e20c8;
            4'h3: v = 32'h26d930ac;
            4'h4: v = 32'h76dc4190;
            4'h5: v = 32'h6b6b51f4;
            4'h6: v = 32'h4db26158;
            4'h7: v = 32'h5005713c;
            4'h8: v = 32'hedb88320;
            4'h9: v = 32'hf00f9344;
            4'ha: v = 32'hd6d6a3e8;
            4'hb: v = 32'hcb61b38c;
            4'hc: v = 32'h9b64c2b0;
            4'hd: v = 32'h86d3d2d4;
            4'he: v = 32'ha00ae278;
            4'hf: v = 32'hbdbdf21c;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Fold one byte into the running CRC: two nibble steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        c = (c >> 4) ^ crc_nib(c[3:0]);
        c = (c >> 4) ^ crc_nib(c[3:0]);
        return c;
    endfunction

endpackage

FILE: rtl/core/stored_png_stream_encoder_core.sv
// Top level: byte sequencer that wraps raw pixel bytes into an uncompressed PNG file.
// Usage
//   Pixel channel (i_pixel_valid / o_pixel_ready / i_pixel_byte) takes raw channel
//   bytes, RGB or RGBA, row-major. The output channel (o_out_valid / i_out_ready)
//   carries the PNG file one byte per transaction, with o_last_of_run on the last
//   byte caused by a pixel byte and o_end_of_file on the final byte of the file.
//   Config channel (i_cfg_valid / o_cfg_ready) writes width, height and alpha flag;
//   always ready. Write only while no pixel is in flight (the block does not check).
// Timing
//   An accepted pixel byte is registered in r_pix; its first output byte is then
//   loaded into the output register once it is free. While i_out_ready stays high,
//   one output byte is emitted per cycle; a pixel byte causes 1 output byte inside a
//   row, 7 at a row start, 43 more for the file header on the first byte and 20 more
//   for the trailer on the last, and inside a row one pixel byte is taken per cycle;
//   the next pixel is taken in the cycle the current one emits its last byte.
// Reset
//   Synchronous reset clears the sequencer and output register and sets the
//   config to width 1, height 1, RGB. The next pixel byte starts a new file.
// Stall
//   When the receiver holds i_out_ready low the output register keeps its byte,
//   the sequencer pauses, and o_pixel_ready stays low while an item is pending.
module stored_png_stream_encoder_core
    import spng_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel channel
    input  logic        i_pixel_valid,
    output logic        o_pixel_ready,
    input  logic [7:0]  i_pixel_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_end_of_file,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    // config registers
    logic [13:0] r_image_width;
    logic [14:0] r_image_height;
    logic        r_has_alpha;
    logic [31:0] r_idat_len;

    // sequencer state
    t_phase      r_phase,    n_phase;
    logic [5:0]  r_idx,      n_idx;
    logic [31:0] r_crc;
    logic [15:0] r_adler_lo, r_adler_hi;
    logic [15:0] r_bir,      n_bir;
    logic [14:0] r_row,      n_row;
    logic        r_busy;
    logic [7:0]  r_pix;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_eof;

    logic [13:0] w_eff;
    logic [14:0] h_eff;
    logic [15:0] w16;
    logic [15:0] row_bytes;
    logic [15:0] pitch;
    logic [15:0] npitch;
    logic        row_final;
    logic [15:0] bir_inc;

    logic [7:0]  hdr_byte;
    logic        hdr_crc_en;
    logic [7:0]  tail_byte;
    logic        tail_crc_en;

    logic [7:0]  emit_byte;
    logic        crc_en;
    logic        crc_restart;
    logic        adler_en;
    logic        adler_reset;
    logic        item_last;
    logic        item_eof;
    logic        stream_clear;
    logic [31:0] crc_next;

    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_new, hi_new;

    logic        out_free;
    logic        fire;
    logic        pix_accept;

    // effective geometry: zero reads as one
    assign w_eff     = (r_image_width  == '0) ? 14'd1 : r_image_width;
    assign h_eff     = (r_image_height == '0) ? 15'd1 : r_image_height;
    assign w16       = {2'd0, w_eff};
    assign row_bytes = (w16 << 1) + w16 + (r_has_alpha ? w16 : 16'd0);
    assign pitch     = row_bytes + 16'd1;
    assign npitch    = ~pitch;
    assign row_final = ({1'b0, r_row} + 16'd1) >= {1'b0, h_eff};
    assign bir_inc   = r_bir + 16'd1;

    // handshakes
    assign out_free      = !r_out_valid || i_out_ready;
    assign fire          = r_busy && out_free;
    assign o_pixel_ready = !r_busy || (fire && item_last);
    assign pix_accept    = i_pixel_valid && o_pixel_ready;
    assign o_cfg_ready   = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_end_of_file = r_out_eof;

    // file header bytes: signature, IHDR, IDAT length and type, zlib header
    always_comb begin
        hdr_crc_en = (r_idx inside {[6'd12:6'd28], [6'd37:6'd42]});
        case (r_idx)
            6'd0:  hdr_byte = 8'h89;
            6'd1:  hdr_byte = 8'h50;
            6'd2:  hdr_byte = 8'h4e;
            6'd3:  hdr_byte = 8'h47;
            6'd4:  hdr_byte = 8'h0d;
            6'd5:  hdr_byte = 8'h0a;
            6'd6:  hdr_byte = 8'h1a;
            6'd7:  hdr_byte = 8'h0a;
            6'd11: hdr_byte = 8'h0d;
            6'd12: hdr_byte = 8'h49;
            6'd13: hdr_byte = 8'h48;
            6'd14: hdr_byte = 8'h44;
            6'd15: hdr_byte = 8'h52;
            6'd18: hdr_byte = {2'd0, w_eff[13:8]};
            6'd19: hdr_byte = w_eff[7:0];
            6'd22: hdr_byte = {1'b0, h_eff[14:8]};
            6'd23: hdr_byte = h_eff[7:0];
            6'd24: hdr_byte = 8'h08;
            6'd25: hdr_byte = r_has_alpha ? COLOR_RGBA : COLOR_RGB;
            6'd29: hdr_byte = ~r_crc[31:24];
            6'd30: hdr_byte = ~r_crc[23:16];
            6'd31: hdr_byte = ~r_crc[15:8];
            6'd32: hdr_byte = ~r_crc[7:0];
            6'd33: hdr_byte = r_idat_len[31:24];
            6'd34: hdr_byte = r_idat_len[23:16];
            6'd35: hdr_byte = r_idat_len[15:8];
            6'd36: hdr_byte = r_idat_len[7:0];
            6'd37: hdr_byte = 8'h49;
            6'd38: hdr_byte = 8'h44;
            6'd39: hdr_byte = 8'h41;
            6'd40: hdr_byte = 8'h54;
            6'd41: hdr_byte = 8'h78;
            6'd42: hdr_byte = 8'h01;
            default: hdr_byte = 8'h00;
        endcase
    end

    // file trailer bytes: Adler word, IDAT CRC, IEND chunk
    always_comb begin
        tail_crc_en = (r_idx inside {[6'd0:6'd3], [6'd12:6'd15]});
        case (r_idx)
            6'd0:  tail_byte = r_adler_hi[15:8];
            6'd1:  tail_byte = r_adler_hi[7:0];
            6'd2:  tail_byte = r_adler_lo[15:8];
            6'd3:  tail_byte = r_adler_lo[7:0];
            6'd4:  tail_byte = ~r_crc[31:24];
            6'd5:  tail_byte = ~r_crc[23:16];
            6'd6:  tail_byte = ~r_crc[15:8];
            6'd7:  tail_byte = ~r_crc[7:0];
            6'd12: tail_byte = 8'h49;
            6'd13: tail_byte = 8'h45;
            6'd14: tail_byte = 8'h4e;
            6'd15: tail_byte = 8'h44;
            6'd16: tail_byte = ~r_crc[31:24];
            6'd17: tail_byte = ~r_crc[23:16];
            6'd18: tail_byte = ~r_crc[15:8];
            6'd19: tail_byte = ~r_crc[7:0];
            default: tail_byte = 8'h00;
        endcase
    end

    // sequencer: next byte and next state
    always_comb begin
        emit_byte    = 8'h00;
        crc_en       = 1'b0;
        crc_restart  = 1'b0;
        adler_en     = 1'b0;
        adler_reset  = 1'b0;
        item_last    = 1'b0;
        item_eof     = 1'b0;
        stream_clear = 1'b0;
        n_phase      = r_phase;
        n_idx        = r_idx + 6'd1;
        n_bir        = r_bir;
        n_row        = r_row;
        case (r_phase)
            S_HDR: begin
                emit_byte   = hdr_byte;
                crc_en      = hdr_crc_en;
                crc_restart = (r_idx == HDR_IHDR_TYPE) || (r_idx == HDR_IDAT_TYPE);
                if (r_idx == HDR_LAST) begin
                    n_phase     = S_ROW;
                    n_idx       = '0;
                    adler_reset = 1'b1;
                    n_bir       = '0;
                    n_row       = '0;
                end
            end
            S_ROW: begin
                crc_en = 1'b1;
                case (r_idx)
                    6'd0:    emit_byte = {7'd0, row_final};
                    6'd1:    emit_byte = pitch[7:0];
                    6'd2:    emit_byte = pitch[15:8];
                    6'd3:    emit_byte = npitch[7:0];
                    6'd4:    emit_byte = npitch[15:8];
                    default: emit_byte = 8'h00;
                endcase
                if (r_idx == ROW_LAST) begin
                    adler_en = 1'b1;
                    n_phase  = S_PIX;
                    n_idx    = '0;
                end
            end
            S_PIX: begin
                emit_byte = r_pix;
                crc_en    = 1'b1;
                adler_en  = 1'b1;
                n_idx     = '0;
                if (bir_inc >= row_bytes) begin
                    n_bir = '0;
                    if (row_final) begin
                        n_phase = S_TAIL;
                    end else begin
                        n_row     = r_row + 15'd1;
                        n_phase   = S_ROW;
                        item_last = 1'b1;
                    end
                end else begin
                    n_bir     = bir_inc;
                    item_last = 1'b1;
                end
            end
            S_TAIL: begin
                emit_byte   = tail_byte;
                crc_en      = tail_crc_en;
                crc_restart = (r_idx == TAIL_IEND_TYPE);
                if (r_idx == TAIL_LAST) begin
                    item_last    = 1'b1;
                    item_eof     = 1'b1;
                    stream_clear = 1'b1;
                    n_phase      = S_HDR;
                    n_idx        = '0;
                    n_bir        = '0;
                    n_row        = '0;
                end
            end
            default: begin
                n_phase = S_HDR;
                n_idx   = '0;
            end
        endcase
    end

    assign crc_next = crc_byte(crc_restart ? CRC_INIT : r_crc, emit_byte);

    // Adler-32 update with single conditional subtract per sum
    assign lo_sum = {1'b0, r_adler_lo} + {9'd0, emit_byte};
    assign lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = {1'b0, r_adler_hi} + {1'b0, lo_new};
    assign hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 14'd1;
            r_image_height <= 15'd1;
            r_has_alpha    <= 1'b0;
            r_phase        <= S_HDR;
            r_idx          <= '0;
            r_crc          <= CRC_INIT;
            r_adler_lo     <= 16'd1;
            r_adler_hi     <= 16'd0;
            r_bir          <= '0;
            r_row          <= '0;
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // config writes; unknown index is ignored
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_image_width  <= i_cfg_data[13:0];
                    CFG_HEIGHT: r_image_height <= i_cfg_data;
                    CFG_ALPHA:  r_has_alpha    <= i_cfg_data[0];
                    default:    ;
                endcase
            end

            // pending item
            if (pix_accept) begin
                r_busy <= 1'b1;
            end else if (fire && item_last) begin
                r_busy <= 1'b0;
            end

            // sequencer advance
            if (fire) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_bir   <= n_bir;
                r_row   <= n_row;
                if (stream_clear) begin
                    r_crc <= CRC_INIT;
                end else if (crc_en) begin
                    r_crc <= crc_next;
                end
                if (stream_clear || adler_reset) begin
                    r_adler_lo <= 16'd1;
                    r_adler_hi <= 16'd0;
                end else if (adler_en) begin
                    r_adler_lo <= lo_new;
                    r_adler_hi <= hi_new;
                end
            end

            // output register
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_pix <= i_pixel_byte;
        end
        if (fire) begin
            r_out_byte <= emit_byte;
            r_out_last <= item_last;
            r_out_eof  <= item_eof;
        end
        // IDAT length = 2 + h * (pitch + 5) + 4, valid long before it is sent
        r_idat_len <= 32'(h_eff * ({1'b0, row_bytes} + 17'd6)) + 32'd6;
    end

`ifndef SYNTH
    a_adler_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_adler_lo} < ADLER_MOD) && ({1'b0, r_adler_hi} < ADLER_MOD))
        else $error("Adler sum out of range");

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == S_TAIL) |-> r_busy)
        else $error("trailer in progress without a pending item");

    a_row_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == S_ROW) |-> (r_idx <= ROW_LAST))
        else $error("row header index overrun");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eof) |-> r_out_last)
        else $error("end of file byte not marked last of run");
`endif

endmodule
